/* rtl/ocdf_pkg.sv */
// Shared types, codes and sizes for the OLED delta flush block.
// Used by the interfaces, the controller, the datapath and the top level.
package ocdf_pkg;

	localparam int FRAME_MAX = 1024;
	localparam int CHUNK_MAX = 64;

	localparam int FRAME_AW  = $clog2(FRAME_MAX);
	localparam int SHADOW_AW = FRAME_AW + 1;
	localparam int CUR_W     = FRAME_AW + 1;
	localparam int CHUNK_AW  = $clog2(CHUNK_MAX);
	localparam int CNT_W     = CHUNK_AW + 1;
	localparam int CMP_W     = ((CUR_W > 11) ? CUR_W : 11) + 1;
	localparam int DIV_CW    = $clog2(CUR_W) + 1;

	localparam logic [7:0] PAGE_CMD       = 8'hB0;
	localparam logic [7:0] START_LINE_CMD = 8'h40;
	localparam logic [7:0] FLIP_LINE      = 8'd32;
	localparam logic [7:0] COL_HIGH_CMD   = 8'h10;
	localparam logic [7:0] NIBBLE_MASK    = 8'h0F;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_FLUSH = 2'd1,
		MODE_ACK   = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		KIND_HEADER = 3'd0,
		KIND_DATA   = 3'd1,
		KIND_FLIP   = 3'd2,
		KIND_DONE   = 3'd3,
		KIND_STATUS = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		PEND_NONE  = 2'd0,
		PEND_CHUNK = 2'd1,
		PEND_FLIP  = 2'd2
	} pend_t;

	typedef enum logic [2:0] {
		CFG_PANEL_WIDTH   = 3'd0,
		CFG_FRAME_BYTES   = 3'd1,
		CFG_CHUNK_BYTES   = 3'd2,
		CFG_COLUMN_OFFSET = 3'd3,
		CFG_PAGE_FLIP     = 3'd4,
		CFG_PANEL_PAGES   = 3'd5,
		CFG_SHADOW_ENABLE = 3'd6
	} cfg_index_t;

	typedef enum logic [1:0] {
		SEL_DATA   = 2'd0,
		SEL_FLIP   = 2'd1,
		SEL_DONE   = 2'd2,
		SEL_STATUS = 2'd3
	} out_sel_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [9:0] fb_address;
		logic [7:0] fb_data;
		logic       bus_ok;
	} item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] page_command;
		logic [7:0] column_low_command;
		logic [7:0] column_high_command;
		logic [7:0] data_byte;
		logic       last;
	} result_t;

	typedef struct packed {
		logic     fb_write;
		logic     ack_apply;
		logic     clear_apply;
		logic     flush_init;
		logic     div_step;
		logic     span_calc;
		logic     cmp_read;
		logic     j_inc;
		logic     j_clr;
		logic     skip_adv;
		logic     emit_read;
		logic     emit_load;
		logic     chunk_set;
		logic     fend_apply;
		logic     copy_read;
		logic     copy_write;
		logic     clr_write;
		logic     out_load;
		out_sel_t out_sel;
	} cmd_t;

	typedef struct packed {
		logic frame_end;
		logic skip_on;
		logic last_j;
		logic eq;
		logic div_last;
		logic out_free;
		logic clr_last;
		logic copy_last;
		logic copy_needed;
	} sts_t;

endpackage

/* rtl/ocdf_if.sv */
// Valid/ready channel interfaces for input items and result items.
// Depends on ocdf_pkg for the payload structs.
interface ocdf_item_if import ocdf_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ocdf_result_if import ocdf_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* rtl/ocdf_ctrl.sv */
// Sequencing state machine of the OLED delta flush block.
// Depends on ocdf_pkg; drives the datapath through cmd_t and reads sts_t.
module ocdf_ctrl import ocdf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_mode,
	output logic       in_ready,
	input  sts_t       sts,
	output cmd_t       cmd
);

	typedef enum logic [11:0] {
		ST_IDLE = 12'b0000_0000_0001,
		ST_DIV  = 12'b0000_0000_0010,
		ST_SPAN = 12'b0000_0000_0100,
		ST_CRD  = 12'b0000_0000_1000,
		ST_CCMP = 12'b0000_0001_0000,
		ST_ERD  = 12'b0000_0010_0000,
		ST_EOUT = 12'b0000_0100_0000,
		ST_FEND = 12'b0000_1000_0000,
		ST_CPRD = 12'b0001_0000_0000,
		ST_CPWR = 12'b0010_0000_0000,
		ST_CLR  = 12'b0100_0000_0000,
		ST_STAT = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd = '0;
		state_d = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (in_mode)
						MODE_WRITE: begin
							cmd.fb_write = 1'b1;
						end
						MODE_FLUSH: begin
							cmd.flush_init = 1'b1;
							state_d = ST_DIV;
						end
						MODE_ACK: begin
							cmd.ack_apply = 1'b1;
							cmd.j_clr = 1'b1;
							state_d = sts.copy_needed ? ST_CPRD : ST_STAT;
						end
						default: begin
							cmd.clear_apply = 1'b1;
							state_d = ST_CLR;
						end
					endcase
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = ST_SPAN;
			end
			ST_SPAN: begin
				cmd.span_calc = 1'b1;
				if (sts.frame_end) state_d = ST_FEND;
				else if (sts.skip_on) state_d = ST_CRD;
				else state_d = ST_ERD;
			end
			ST_CRD: begin
				cmd.cmp_read = 1'b1;
				state_d = ST_CCMP;
			end
			ST_CCMP: begin
				if (!sts.eq) begin
					cmd.j_clr = 1'b1;
					state_d = ST_ERD;
				end else if (sts.last_j) begin
					cmd.skip_adv = 1'b1;
					state_d = ST_SPAN;
				end else begin
					cmd.j_inc = 1'b1;
					state_d = ST_CRD;
				end
			end
			ST_ERD: begin
				cmd.emit_read = 1'b1;
				state_d = ST_EOUT;
			end
			ST_EOUT: begin
				if (sts.out_free) begin
					cmd.emit_load = 1'b1;
					cmd.out_load = 1'b1;
					cmd.out_sel = SEL_DATA;
					if (sts.last_j) begin
						cmd.chunk_set = 1'b1;
						state_d = ST_IDLE;
					end else begin
						cmd.j_inc = 1'b1;
						state_d = ST_ERD;
					end
				end
			end
			ST_FEND: begin
				if (sts.out_free) begin
					cmd.fend_apply = 1'b1;
					cmd.out_load = 1'b1;
					cmd.out_sel = SEL_FLIP;
					state_d = ST_IDLE;
				end
			end
			ST_CPRD: begin
				cmd.copy_read = 1'b1;
				state_d = ST_CPWR;
			end
			ST_CPWR: begin
				cmd.copy_write = 1'b1;
				if (sts.copy_last) begin
					state_d = ST_STAT;
				end else begin
					cmd.j_inc = 1'b1;
					state_d = ST_CPRD;
				end
			end
			ST_CLR: begin
				cmd.clr_write = 1'b1;
				if (sts.clr_last) state_d = ST_STAT;
			end
			ST_STAT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel = SEL_STATUS;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/ocdf_datapath.sv */
// Datapath of the OLED delta flush block: registers, stores, divider, result register.
// Depends on ocdf_pkg; commanded by ocdf_ctrl through cmd_t.
module ocdf_datapath import ocdf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [10:0] cfg_wdata,
	input  item_t      item,
	input  cmd_t       cmd,
	output sts_t       sts,
	input  logic       res_ready,
	output logic       res_valid,
	output result_t    res
);

	logic [7:0]  width_q;
	logic [10:0] frame_q;
	logic [6:0]  chunk_q;
	logic [3:0]  coloff_q;
	logic        flip_q;
	logic [3:0]  pages_q;
	logic        shen_q;

	logic [CUR_W-1:0]     cursor_q;
	logic                 mid_q;
	logic [1:0]           vmask_q;
	logic                 back_q;
	pend_t                pk_q;
	logic [CNT_W-1:0]     plen_q;
	logic [SHADOW_AW-1:0] paddr_q;
	logic                 stat_q;

	logic [CUR_W-1:0]     page_q;
	logic [7:0]           col_q;
	logic [DIV_CW-1:0]    div_cnt_q;
	logic [CNT_W-1:0]     s_q;
	logic [CNT_W-1:0]     j_q;
	logic [SHADOW_AW-1:0] clr_q;

	logic [7:0] frame_mem [FRAME_MAX];
	logic [7:0] shadow_mem [2*FRAME_MAX];
	logic [7:0] pend_mem [CHUNK_MAX];
	logic [7:0] frame_rd_q;
	logic [7:0] shadow_rd_q;
	logic [7:0] pend_rd_q;

	logic [7:0]           width_e;
	logic [CUR_W-1:0]     frame_e;
	logic [CNT_W-1:0]     chunk_e;
	logic [8:0]           left;
	logic [CUR_W-1:0]     rest;
	logic [CNT_W-1:0]     span_d;
	logic [CUR_W-1:0]     soff;
	logic [SHADOW_AW-1:0] sh_addr;
	logic [FRAME_AW-1:0]  fr_addr;
	logic [8:0]           trial;
	logic                 qbit;
	logic [8:0]           col_sum;
	logic [4:0]           base;
	logic [CUR_W-1:0]     page_sum;
	logic [7:0]           hw_col;
	logic                 first_j;
	result_t              res_d;

	// Effective register values.
	always_comb begin
		width_e = (width_q == 8'd0) ? 8'd1 : width_q;
		frame_e = (CMP_W'(frame_q) > CMP_W'(FRAME_MAX)) ? CUR_W'(FRAME_MAX) : CUR_W'(frame_q);
		if (chunk_q == 7'd0) chunk_e = CNT_W'(1);
		else if (chunk_q > 7'(CHUNK_MAX)) chunk_e = CNT_W'(CHUNK_MAX);
		else chunk_e = CNT_W'(chunk_q);
	end

	// Run length at the cursor: limited by chunk size, page end and frame end.
	always_comb begin
		left = {1'b0, width_e} - {1'b0, col_q};
		rest = frame_e - cursor_q;
		span_d = chunk_e;
		if (CMP_W'(left) < CMP_W'(span_d)) span_d = CNT_W'(left);
		if (CMP_W'(rest) < CMP_W'(span_d)) span_d = CNT_W'(rest);
	end

	always_comb begin
		soff = (flip_q && back_q) ? frame_e : '0;
		sh_addr = SHADOW_AW'(soff) + SHADOW_AW'(cursor_q) + SHADOW_AW'(j_q);
		fr_addr = FRAME_AW'(cursor_q + CUR_W'(j_q));
		trial = {col_q, page_q[CUR_W-1]};
		qbit = (trial >= {1'b0, width_e});
		col_sum = {1'b0, col_q} + 9'(s_q);
		base = flip_q ? (back_q ? {1'b0, pages_q} : 5'd0) : 5'd0;
		page_sum = page_q + CUR_W'(base);
		hw_col = col_q + {4'd0, coloff_q};
		first_j = (j_q == '0);
	end

	always_comb begin
		sts.frame_end = CMP_W'(cursor_q) >= CMP_W'(frame_e);
		sts.skip_on = shen_q && vmask_q[back_q];
		sts.last_j = ((CNT_W + 1)'(j_q) + 1'b1) == (CNT_W + 1)'(s_q);
		sts.eq = (frame_rd_q == shadow_rd_q);
		sts.div_last = (div_cnt_q == DIV_CW'(CUR_W - 1));
		sts.out_free = !res_valid || res_ready;
		sts.clr_last = (clr_q == SHADOW_AW'(2*FRAME_MAX - 1));
		sts.copy_last = ((CNT_W + 1)'(j_q) + 1'b1) == (CNT_W + 1)'(plen_q);
		sts.copy_needed = item.bus_ok && (pk_q == PEND_CHUNK) && shen_q;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 8'd128;
			frame_q  <= 11'd1024;
			chunk_q  <= 7'd32;
			coloff_q <= 4'd0;
			flip_q   <= 1'b0;
			pages_q  <= 4'd8;
			shen_q   <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PANEL_WIDTH:   width_q  <= cfg_wdata[7:0];
				CFG_FRAME_BYTES:   frame_q  <= cfg_wdata;
				CFG_CHUNK_BYTES:   chunk_q  <= cfg_wdata[6:0];
				CFG_COLUMN_OFFSET: coloff_q <= cfg_wdata[3:0];
				CFG_PAGE_FLIP:     flip_q   <= cfg_wdata[0];
				CFG_PANEL_PAGES:   pages_q  <= cfg_wdata[3:0];
				CFG_SHADOW_ENABLE: shen_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Frame, pending and display state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			mid_q    <= 1'b0;
			vmask_q  <= 2'b00;
			back_q   <= 1'b0;
			pk_q     <= PEND_NONE;
			plen_q   <= '0;
			paddr_q  <= '0;
			stat_q   <= 1'b0;
		end else begin
			priority if (cmd.ack_apply) begin
				stat_q <= item.bus_ok && (pk_q == PEND_CHUNK || pk_q == PEND_FLIP);
				if (item.bus_ok && pk_q == PEND_CHUNK) begin
					cursor_q <= CUR_W'(cursor_q + CUR_W'(plen_q));
				end
				if (item.bus_ok && pk_q == PEND_FLIP) begin
					vmask_q[back_q] <= 1'b1;
					back_q <= !back_q;
					mid_q <= 1'b0;
				end
				pk_q <= PEND_NONE;
			end else if (cmd.clear_apply) begin
				vmask_q  <= shen_q ? (flip_q ? 2'b11 : 2'b01) : 2'b00;
				back_q   <= flip_q;
				cursor_q <= '0;
				mid_q    <= 1'b0;
				pk_q     <= PEND_NONE;
				stat_q   <= 1'b1;
			end else if (cmd.flush_init) begin
				pk_q <= PEND_NONE;
				if (!mid_q) begin
					cursor_q <= '0;
					mid_q <= 1'b1;
				end
			end else if (cmd.skip_adv) begin
				cursor_q <= cursor_q + CUR_W'(s_q);
			end else if (cmd.chunk_set) begin
				pk_q    <= PEND_CHUNK;
				plen_q  <= s_q;
				paddr_q <= SHADOW_AW'(soff) + SHADOW_AW'(cursor_q);
			end else if (cmd.fend_apply) begin
				if (flip_q) begin
					pk_q <= PEND_FLIP;
				end else begin
					if (shen_q) vmask_q[0] <= 1'b1;
					mid_q <= 1'b0;
				end
			end
		end
	end

	// Divider for page and column, run length and byte index.
	always_ff @(posedge clk) begin
		if (cmd.flush_init) begin
			page_q    <= mid_q ? cursor_q : '0;
			col_q     <= 8'd0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			page_q    <= {page_q[CUR_W-2:0], qbit};
			col_q     <= qbit ? 8'(trial - {1'b0, width_e}) : trial[7:0];
			div_cnt_q <= div_cnt_q + 1'b1;
		end else if (cmd.skip_adv) begin
			if (col_sum == {1'b0, width_e}) begin
				col_q  <= 8'd0;
				page_q <= page_q + 1'b1;
			end else begin
				col_q <= col_sum[7:0];
			end
		end
		if (cmd.span_calc) s_q <= span_d;
		if (cmd.span_calc || cmd.j_clr) j_q <= '0;
		else if (cmd.j_inc) j_q <= j_q + 1'b1;
		if (cmd.clear_apply) clr_q <= '0;
		else if (cmd.clr_write) clr_q <= clr_q + 1'b1;
	end

	// Stores.
	always_ff @(posedge clk) begin
		if (cmd.fb_write && (CMP_W'(item.fb_address) < CMP_W'(FRAME_MAX))) begin
			frame_mem[FRAME_AW'(item.fb_address)] <= item.fb_data;
		end
		if (cmd.cmp_read || cmd.emit_read) frame_rd_q <= frame_mem[fr_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_write) shadow_mem[clr_q] <= 8'd0;
		else if (cmd.copy_write) shadow_mem[paddr_q + SHADOW_AW'(j_q)] <= pend_rd_q;
		if (cmd.cmp_read) shadow_rd_q <= shadow_mem[sh_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) pend_mem[j_q[CHUNK_AW-1:0]] <= frame_rd_q;
		if (cmd.copy_read) pend_rd_q <= pend_mem[j_q[CHUNK_AW-1:0]];
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	// Next result, assembled from the selected source.
	always_comb begin
		res_d = '0;
		res_d.last = 1'b1;
		unique case (cmd.out_sel)
			SEL_DATA: begin
				res_d.kind = first_j ? KIND_HEADER : KIND_DATA;
				res_d.data_byte = frame_rd_q;
				res_d.last = sts.last_j;
				if (first_j) begin
					res_d.page_command = PAGE_CMD | page_sum[7:0];
					res_d.column_low_command = hw_col & NIBBLE_MASK;
					res_d.column_high_command = COL_HIGH_CMD | {4'd0, hw_col[7:4]};
				end
			end
			SEL_FLIP: begin
				if (flip_q) begin
					res_d.kind = KIND_FLIP;
					res_d.data_byte = START_LINE_CMD | (back_q ? FLIP_LINE : 8'd0);
				end else begin
					res_d.kind = KIND_DONE;
				end
			end
			SEL_DONE: begin
				res_d.kind = KIND_DONE;
			end
			SEL_STATUS: begin
				res_d.kind = KIND_STATUS;
				res_d.data_byte = {7'd0, stat_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) res <= res_d;
	end

endmodule

/* rtl/oled_delta_chunk_flush_unit.sv */
// Write item: stored in the frame store, no result. Flush: a divider splits the cursor into
// page and column, then bytes are compared against the shadow (read and compare states)
// and sent (read and output states); the single-port stores set this pace.
// Acknowledge: pending bytes are copied into the shadow when needed, then the status result.
// Panel cleared: a pass zeroes the shadow, then the status result. One item is worked on at a time.
// Reset (arst_n low) clears all control state and loads register defaults; stores are not cleared.
module oled_delta_chunk_flush_unit import ocdf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_wdata,
	ocdf_item_if.sink   item,
	ocdf_result_if.source result
);

	// Command and status bundles between the sequencer and the datapath.
	cmd_t cmd;
	sts_t sts;

	// The controller owns the input handshake; a transfer happens only in its idle state.
	ocdf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_mode  (item.payload.mode),
		.in_ready (item.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the stores, the cursor state and the result register, which
	// lets a finished result wait for its transfer while the next item is taken.
	ocdf_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.item      (item.payload),
		.cmd       (cmd),
		.sts       (sts),
		.res_ready (result.ready),
		.res_valid (result.valid),
		.res       (result.payload)
	);

	// Any item other than a framebuffer write makes the block busy, so no item is taken right after it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && item.payload.mode != MODE_WRITE) |=> !item.ready)
		else $error("input taken while a flush, acknowledge or clear is in progress");

	// Status, flip and frame-done results always close their item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.payload.kind == KIND_STATUS ||
		 result.payload.kind == KIND_FLIP || result.payload.kind == KIND_DONE))
		|-> result.payload.last)
		else $error("single-result item without last flag");

	// A new result is loaded only when the result register is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!result.valid || result.ready))
		else $error("result register overwritten before transfer");

endmodule
